// ----- src/f2i_pkg.sv -----
// ----------------------------------------------------------------------------
// f2i_pkg
// Types and constants for the IEEE float to int32 PCM sample converter.
// ----------------------------------------------------------------------------
package f2i_pkg;

  // Register map (word index)
  localparam int unsigned RegSampleIsDouble = 0;
  localparam int unsigned PaddrWidth        = 3;

  // binary64 / binary32 field constants
  localparam logic [10:0] DblExpSpecial = 11'h7FF;
  localparam logic [7:0]  SglExpSpecial = 8'hFF;
  localparam int          DblBias       = 1023;
  localparam int          SglBias       = 127;

  // PCM limits
  localparam logic signed [31:0] PcmMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] PcmMin = 32'sh8000_0000;

  // Truncated magnitude thresholds
  localparam logic [32:0] MagLimit = 33'h0_8000_0000;

  // Valid right-shift range for the rounded product
  localparam logic [5:0] ShiftLow  = 6'd21;
  localparam logic [5:0] ShiftHigh = 6'd53;

  typedef struct packed {
    logic [63:0] sample_bits;
    logic        last_sample;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] pcm_sample;
    logic               clipped;
    logic               last_out;
  } pcm_t;

endpackage

// ----- src/float_to_int32_pcm_convert.sv -----
// A sample passes the input, rounded-product and output registers in order before pcm.
// Throughput: one sample per cycle; a stage advances whenever the next one can take it,
// so bubbles close up and the input stalls only with all three stages full.
// Stage 1 registers the raw word, stage 2 holds the exactly rounded product,
// stage 3 holds the truncated and saturated sample.
// Reset (rst, synchronous): all stages empty, sample_is_double cleared to 0.
// ----------------------------------------------------------------------------
// float_to_int32_pcm_convert
// Converts binary32/binary64 audio samples to signed 32-bit PCM with
// saturation and a clip flag.
// ----------------------------------------------------------------------------
module float_to_int32_pcm_convert (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  f2i_pkg::sample_t              sample,
  output logic                          pcm_valid,
  input  logic                          pcm_ready,
  output f2i_pkg::pcm_t                 pcm,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [f2i_pkg::PaddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import f2i_pkg::*;

  logic sample_is_double;

  // Stage A: input register
  logic    a_valid;
  sample_t a_data;

  // Stage B: rounded product
  logic        b_valid;
  logic        b_sign;
  logic        b_nan;
  logic        b_big;
  logic        b_tiny;
  logic [53:0] b_round;
  logic [5:0]  b_shift;
  logic        b_last;

  // Stage C: output register
  logic c_valid;
  pcm_t c_data;

  logic a_ready, b_ready, c_ready;

  // Register port
  assign pready = 1'b1;
  assign prdata = {31'b0, sample_is_double};

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_is_double <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[PaddrWidth-1:2] == RegSampleIsDouble[PaddrWidth-3:0]) begin
        sample_is_double <= pwdata[0];
      end
    end
  end

  // Pipeline flow control
  assign c_ready      = !c_valid || pcm_ready;
  assign b_ready      = !b_valid || c_ready;
  assign a_ready      = !a_valid || b_ready;
  assign sample_ready = a_ready;
  assign pcm_valid    = c_valid;
  assign pcm          = c_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && sample_valid) begin
      a_data <= sample;
    end
  end

  // Decode, exact product by (2^31 - 1), round to 53 bits
  logic               d_sign;
  logic               d_special;
  logic               d_zero_exp;
  logic               d_frac_nz;
  logic signed [12:0] d_exp;
  logic [52:0]        d_mant;
  logic [83:0]        d_prod;
  logic               d_hi;
  logic [52:0]        d_keep;
  logic               d_guard;
  logic               d_sticky;
  logic [53:0]        d_round;
  logic signed [12:0] d_shift;

  always_comb begin
    if (sample_is_double) begin
      d_sign     = a_data.sample_bits[63];
      d_special  = a_data.sample_bits[62:52] == DblExpSpecial;
      d_zero_exp = a_data.sample_bits[62:52] == 11'd0;
      d_frac_nz  = |a_data.sample_bits[51:0];
      d_exp      = $signed({2'b00, a_data.sample_bits[62:52]}) - 13'(DblBias);
      d_mant     = {1'b1, a_data.sample_bits[51:0]};
    end else begin
      d_sign     = a_data.sample_bits[31];
      d_special  = a_data.sample_bits[30:23] == SglExpSpecial;
      d_zero_exp = a_data.sample_bits[30:23] == 8'd0;
      d_frac_nz  = |a_data.sample_bits[22:0];
      d_exp      = $signed({5'b0, a_data.sample_bits[30:23]}) - 13'(SglBias);
      d_mant     = {1'b1, a_data.sample_bits[22:0], 29'b0};
    end
    d_prod = {d_mant, 31'b0} - {31'b0, d_mant};
    d_hi   = d_prod[83];
    if (d_hi) begin
      d_keep   = d_prod[83:31];
      d_guard  = d_prod[30];
      d_sticky = |d_prod[29:0];
    end else begin
      d_keep   = d_prod[82:30];
      d_guard  = d_prod[29];
      d_sticky = |d_prod[28:0];
    end
    d_round = {1'b0, d_keep} + 54'(d_guard && (d_sticky || d_keep[0]));
    d_shift = 13'sd22 - d_exp - $signed({12'b0, d_hi});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_sign  <= d_sign;
      b_nan   <= d_special && d_frac_nz;
      b_big   <= (d_special && !d_frac_nz) || (!d_special && !d_zero_exp && d_exp >= 13'sd1);
      b_tiny  <= !d_special && (d_zero_exp || d_exp <= -13'sd32);
      b_round <= d_round;
      b_shift <= d_shift[5:0];
      b_last  <= a_data.last_sample;
    end
  end

  // Truncate toward zero and saturate
  logic [53:0] t_full;
  logic [32:0] t_mag;
  pcm_t        t_res;

  always_comb begin
    t_full           = b_round >> b_shift;
    t_mag            = t_full[32:0];
    t_res.last_out   = b_last;
    t_res.clipped    = 1'b0;
    t_res.pcm_sample = '0;
    if (b_nan) begin
      t_res.clipped = 1'b1;
    end else if (b_tiny) begin
      t_res.pcm_sample = '0;
    end else if (!b_sign) begin
      if (b_big || t_mag >= MagLimit) begin
        t_res.pcm_sample = PcmMax;
        t_res.clipped    = 1'b1;
      end else begin
        t_res.pcm_sample = $signed(t_mag[31:0]);
      end
    end else begin
      if (b_big || t_mag > MagLimit) begin
        t_res.pcm_sample = PcmMin;
        t_res.clipped    = 1'b1;
      end else begin
        t_res.pcm_sample = $signed(32'd0 - t_mag[31:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && b_valid) begin
      c_data <= t_res;
    end
  end

`ifndef ASSERT_OFF
  // A clipped result is a limit, or zero for NaN
  assert property (@(posedge clk) disable iff (rst)
    c_valid && c_data.clipped |->
      c_data.pcm_sample == PcmMax || c_data.pcm_sample == PcmMin ||
      c_data.pcm_sample == '0)
    else $error("clipped result is not a limit or zero");

  // Back-pressure reaches the input only when every stage is full
  assert property (@(posedge clk) disable iff (rst)
    !sample_ready |-> a_valid && b_valid && c_valid && !pcm_ready)
    else $error("input stalled with an empty stage");

  // In-range samples carry a shift inside the truncation window
  assert property (@(posedge clk) disable iff (rst)
    b_valid && !b_nan && !b_big && !b_tiny |->
      b_shift >= ShiftLow && b_shift <= ShiftHigh)
    else $error("product shift out of range");

  // A stalled output stage keeps its result
  assert property (@(posedge clk) disable iff (rst)
    c_valid && !pcm_ready |=> c_valid && $stable(c_data))
    else $error("output stage changed while stalled");
`endif

endmodule
